[rtl/keyed_record_store_first_fit_assert.svh]
// ---------------------------------------------------------------------------
// keyed record store assertion macros
// clocked, reset-qualified property shorthands
// ---------------------------------------------------------------------------
`ifndef KEYED_RECORD_STORE_FIRST_FIT_ASSERT_SVH
`define KEYED_RECORD_STORE_FIRST_FIT_ASSERT_SVH

// same-cycle implication
`define KST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kst assertion failed");

// next-cycle implication
`define KST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kst assertion failed");

`endif

[rtl/kst_pkg.sv]
// ---------------------------------------------------------------------------
// kst_pkg
// shared constants and codes of the keyed record store
// ---------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  localparam int KeySlotsDef  = 32;
  localparam int DataBytesDef = 1024;
  localparam int SumW         = 17;

  localparam logic [2:0] FnWrite  = 3'd0;
  localparam logic [2:0] FnRead   = 3'd1;
  localparam logic [2:0] FnDelete = 3'd2;
  localparam logic [2:0] FnExists = 3'd3;
  localparam logic [2:0] FnFree   = 3'd4;
  localparam logic [2:0] FnFormat = 3'd5;

  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StBadLen      = 3'd1;
  localparam logic [2:0] StNotFound    = 3'd2;
  localparam logic [2:0] StLenMismatch = 3'd3;
  localparam logic [2:0] StNoSlot      = 3'd4;
  localparam logic [2:0] StNoSpace     = 3'd5;
  localparam logic [2:0] StNoOpen      = 3'd6;
  localparam logic [2:0] StBeyond      = 3'd7;

endpackage

`default_nettype wire

[rtl/kst_if.sv]
// ---------------------------------------------------------------------------
// kst channel interfaces
// valid/ready channels for request items and result items
// ---------------------------------------------------------------------------
`default_nettype none

interface kst_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [15:0] key;
  logic [7:0]  record_length;
  logic [7:0]  byte_index;
  logic [7:0]  data_byte;
  modport source (output valid, func, key, record_length, byte_index, data_byte,
                  input ready);
  modport sink   (input valid, func, key, record_length, byte_index, data_byte,
                  output ready);
endinterface

interface kst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  read_byte;
  logic [10:0] free_bytes;
  modport source (output valid, status, read_byte, free_bytes, input ready);
  modport sink   (input valid, status, read_byte, free_bytes, output ready);
endinterface

`default_nettype wire

[rtl/kst_ram.sv]
// ---------------------------------------------------------------------------
// kst_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module kst_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/keyed_record_store_first_fit.sv]
// ---------------------------------------------------------------------------
// keyed_record_store_first_fit
// keyed record store with a slot table and a first-fit data area
// ---------------------------------------------------------------------------
// usage
// - in_i carries one request item (func, key, record_length, byte_index,
//   data_byte); out_o returns exactly one result item per request
// - in_i.ready is high only while the block is idle: one request at a time,
//   with the block back in idle after each result before the next acceptance
// - a later write byte or an early error goes from dispatch straight to the result
// - lookup, delete, exists and free query scan the slot ram once; a read
//   then reads the data ram as well
// - a write at byte index 0 that allocates adds first-fit passes over the
//   slot ram, repeated while a pass moves the candidate: at most one pass
//   per record it has to skip plus one
// - format sweeps the data ram writing 0xff
// - after reset the same sweep runs before the first item is taken
// - results sit in an output register; a stalled receiver holds the block
//   only once its next result is ready
// ---------------------------------------------------------------------------
`default_nettype none

`include "keyed_record_store_first_fit_assert.svh"

module keyed_record_store_first_fit import kst_pkg::*; #(
  parameter int KEY_SLOTS  = KeySlotsDef,
  parameter int DATA_BYTES = DataBytesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kst_in_if.sink    in_i,
  kst_out_if.source out_o
);

  localparam int Sw  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int Aw  = $clog2(DATA_BYTES);
  localparam int Cw  = Aw + 2;
  localparam int Slw = 16 + Aw + 8;

  // controller states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_FIT   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_CLR   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0] state_q, state_d;

  // latched request item
  logic [2:0]  f_q, f_d;
  logic [15:0] key_q, key_d;
  logic [7:0]  len_q, len_d, idx_q, idx_d, dat_q, dat_d;

  // pending result
  logic [2:0]  st_q, st_d;
  logic [7:0]  rb_q, rb_d;
  logic [10:0] fb_q, fb_d;

  // output register
  logic        ov_q, ov_d;
  logic [2:0]  os_q, os_d;
  logic [7:0]  orb_q, orb_d;
  logic [10:0] ofb_q, ofb_d;

  // slot valid marks in flops, the rest of each slot in ram
  logic [KEY_SLOTS-1:0] valid_q, valid_d;

  // open write
  logic          open_q, open_d;
  logic [Aw-1:0] obase_q, obase_d;
  logic [7:0]    olen_q, olen_d;

  // slot scan: cnt is the address being read, pidx the slot whose data is back
  logic [Sw-1:0] cnt_q, cnt_d, pidx_q, pidx_d;
  logic          issue_q, issue_d, pv_q, pv_d;

  // scan results
  logic          mf_q, mf_d, ef_q, ef_d;
  logic [Sw-1:0] midx_q, midx_d, eidx_q, eidx_d;
  logic [Aw-1:0] moff_q, moff_d;
  logic [7:0]    mlen_q, mlen_d;
  logic [SumW-1:0] sum_q, sum_d;

  // first-fit candidate base and pass hit flag
  logic [Cw-1:0] cand_q, cand_d;
  logic          hit_q, hit_d;

  // clearing sweep
  logic [Aw-1:0] clr_q, clr_d;
  logic          fmt_q, fmt_d;

  // ram ports
  logic           swe;
  logic [Sw-1:0]  swaddr;
  logic [Slw-1:0] swdata, srdata;
  logic           dwe;
  logic [Aw-1:0]  dwaddr, draddr;
  logic [7:0]     dwdata, drdata;

  logic [15:0]   s_key;
  logic [Aw-1:0] s_off;
  logic [7:0]    s_len;
  logic          s_vld, last, ovl;
  logic [Cw-1:0] cand_n, s_end;
  logic [Sw-1:0] esel;
  logic [SumW-1:0] fsum;

  kst_ram #(.Width(Slw), .Depth(KEY_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (swe),
    .waddr_i (swaddr),
    .wdata_i (swdata),
    .raddr_i (cnt_q),
    .rdata_o (srdata)
  );

  kst_ram #(.Width(8), .Depth(DATA_BYTES)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dwe),
    .waddr_i (dwaddr),
    .wdata_i (dwdata),
    .raddr_i (draddr),
    .rdata_o (drdata)
  );

  assign {s_key, s_off, s_len} = srdata;
  assign s_vld = valid_q[pidx_q];
  assign last  = pv_q && (pidx_q == Sw'(KEY_SLOTS - 1));
  assign s_end = Cw'(s_off) + Cw'(s_len);
  // slot overlaps the candidate run [cand, cand + len)
  assign ovl   = s_vld && (Cw'(s_off) < cand_q + Cw'(len_q)) && (cand_q < s_end);
  assign cand_n = (pv_q && ovl) ? s_end : cand_q;
  // lowest free slot once the old record of this key is dropped
  assign esel  = (mf_q && (!ef_q || (midx_q < eidx_q))) ? midx_q : eidx_q;
  assign fsum  = (sum_q < SumW'(DATA_BYTES)) ? (SumW'(DATA_BYTES) - sum_q) : '0;

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = ov_q;
  assign out_o.status     = os_q;
  assign out_o.read_byte  = orb_q;
  assign out_o.free_bytes = ofb_q;

  always_comb begin
    state_d = state_q;
    f_d = f_q; key_d = key_q; len_d = len_q; idx_d = idx_q; dat_d = dat_q;
    st_d = st_q; rb_d = rb_q; fb_d = fb_q;
    ov_d = ov_q && !out_o.ready;
    os_d = os_q; orb_d = orb_q; ofb_d = ofb_q;
    valid_d = valid_q;
    open_d = open_q; obase_d = obase_q; olen_d = olen_q;
    cnt_d = cnt_q; pidx_d = cnt_q; issue_d = issue_q; pv_d = 1'b0;
    mf_d = mf_q; ef_d = ef_q; midx_d = midx_q; eidx_d = eidx_q;
    moff_d = moff_q; mlen_d = mlen_q; sum_d = sum_q;
    cand_d = cand_q; hit_d = hit_q;
    clr_d = clr_q; fmt_d = fmt_q;
    swe = 1'b0; swaddr = eidx_q; swdata = {key_q, cand_q[Aw-1:0], len_q};
    dwe = 1'b0; dwaddr = obase_q + Aw'(idx_q); dwdata = dat_q;
    draddr = moff_q + Aw'(idx_q);

    // slot read pipeline
    if (state_q == S_SCAN || state_q == S_FIT) begin
      pv_d = issue_q;
      if (issue_q) begin
        if (cnt_q == Sw'(KEY_SLOTS - 1)) begin
          issue_d = 1'b0;
        end else begin
          cnt_d = cnt_q + Sw'(1);
        end
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          f_d = in_i.func; key_d = in_i.key; len_d = in_i.record_length;
          idx_d = in_i.byte_index; dat_d = in_i.data_byte;
          state_d = S_START;
        end
      end
      S_START: begin
        st_d = StOk; rb_d = '0; fb_d = '0;
        mf_d = 1'b0; ef_d = 1'b0; sum_d = '0;
        cnt_d = '0; issue_d = 1'b1;
        state_d = S_SCAN;
        case (f_q)
          FnWrite: begin
            if (idx_q == 8'd0) begin
              open_d = 1'b0;
              if (len_q == 8'd0) begin
                st_d = StBadLen; state_d = S_EMIT;
              end
            end else begin
              state_d = S_EMIT;
              if (!open_q) begin
                st_d = StNoOpen;
              end else if (idx_q >= olen_q) begin
                st_d = StBeyond;
              end else begin
                dwe = 1'b1;
              end
            end
          end
          FnRead: begin
            if (len_q == 8'd0) begin
              st_d = StBadLen; state_d = S_EMIT;
            end
          end
          FnDelete, FnExists, FnFree: begin
          end
          FnFormat: begin
            valid_d = '0; open_d = 1'b0; clr_d = '0; fmt_d = 1'b1;
            state_d = S_CLR;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_SCAN: begin
        if (pv_q) begin
          if (s_vld && (s_key == key_q) && !mf_q) begin
            mf_d = 1'b1; midx_d = pidx_q; moff_d = s_off; mlen_d = s_len;
          end
          if (!s_vld && !ef_q) begin
            ef_d = 1'b1; eidx_d = pidx_q;
          end
          if (s_vld) begin
            sum_d = sum_q + SumW'(s_len);
          end
        end
        if (last) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_EMIT;
        case (f_q)
          FnWrite: begin
            if (mf_q && (mlen_q == len_q)) begin
              // same key, same length: rewrite in place
              dwe = 1'b1; dwaddr = moff_q;
              open_d = 1'b1; obase_d = moff_q; olen_d = len_q;
            end else begin
              if (mf_q) begin
                valid_d[midx_q] = 1'b0;
              end
              if (!(mf_q || ef_q)) begin
                st_d = StNoSlot;
              end else begin
                eidx_d = esel;
                cand_d = '0; hit_d = 1'b0;
                cnt_d = '0; issue_d = 1'b1;
                state_d = S_FIT;
              end
            end
          end
          FnRead: begin
            if (!mf_q) begin
              st_d = StNotFound;
            end else if (mlen_q != len_q) begin
              st_d = StLenMismatch;
            end else if (idx_q >= len_q) begin
              st_d = StBeyond;
            end else begin
              state_d = S_RD;
            end
          end
          FnDelete: begin
            if (!mf_q) begin
              st_d = StNotFound;
            end else begin
              valid_d[midx_q] = 1'b0;
              if (open_q && (obase_q == moff_q)) begin
                open_d = 1'b0;
              end
            end
          end
          FnExists: begin
            if (!mf_q) begin
              st_d = StNotFound;
            end
          end
          FnFree: fb_d = fsum[10:0];
          default: ;
        endcase
      end
      S_FIT: begin
        cand_d = cand_n;
        if (pv_q && ovl) begin
          hit_d = 1'b1;
        end
        if (last) begin
          if (cand_n + Cw'(len_q) > Cw'(DATA_BYTES)) begin
            st_d = StNoSpace; state_d = S_EMIT;
          end else if (hit_q || ovl) begin
            // something moved the candidate: check it again
            hit_d = 1'b0; cnt_d = '0; issue_d = 1'b1;
          end else begin
            swe = 1'b1; swdata = {key_q, cand_n[Aw-1:0], len_q};
            valid_d[eidx_q] = 1'b1;
            dwe = 1'b1; dwaddr = cand_n[Aw-1:0];
            open_d = 1'b1; obase_d = cand_n[Aw-1:0]; olen_d = len_q;
            state_d = S_EMIT;
          end
        end
      end
      S_RD: begin
        rb_d = drdata;
        state_d = S_EMIT;
      end
      S_CLR: begin
        dwe = 1'b1; dwaddr = clr_q; dwdata = 8'hFF;
        clr_d = clr_q + Aw'(1);
        if (clr_q == Aw'(DATA_BYTES - 1)) begin
          fmt_d = 1'b0;
          state_d = fmt_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1; os_d = st_q; orb_d = rb_q; ofb_d = fb_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ov_q    <= 1'b0;
      valid_q <= '0;
      open_q  <= 1'b0;
      obase_q <= '0;
      olen_q  <= '0;
      issue_q <= 1'b0;
      pv_q    <= 1'b0;
      cnt_q   <= '0;
      pidx_q  <= '0;
      clr_q   <= '0;
      fmt_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      valid_q <= valid_d;
      open_q  <= open_d;
      obase_q <= obase_d;
      olen_q  <= olen_d;
      issue_q <= issue_d;
      pv_q    <= pv_d;
      cnt_q   <= cnt_d;
      pidx_q  <= pidx_d;
      clr_q   <= clr_d;
      fmt_q   <= fmt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    f_q <= f_d; key_q <= key_d; len_q <= len_d; idx_q <= idx_d; dat_q <= dat_d;
    st_q <= st_d; rb_q <= rb_d; fb_q <= fb_d;
    os_q <= os_d; orb_q <= orb_d; ofb_q <= ofb_d;
    mf_q <= mf_d; ef_q <= ef_d; midx_q <= midx_d; eidx_q <= eidx_d;
    moff_q <= moff_d; mlen_q <= mlen_d; sum_q <= sum_d;
    cand_q <= cand_d; hit_q <= hit_d;
  end

  // an open record always lies inside the data area
  `KST_ASSERT_IMPL(a_open_fits, open_q,
    (Cw'(obase_q) + Cw'(olen_q) <= Cw'(DATA_BYTES)) && (olen_q != 8'd0))
  // the clearing sweep runs with no records and no open write
  `KST_ASSERT_IMPL(a_clr_empty, state_q == S_CLR, (valid_q == '0) && !open_q)
  // a taken item always goes to dispatch next
  `KST_ASSERT_NEXT(a_accept_start, in_i.valid && in_i.ready, state_q == S_START)

endmodule

`default_nettype wire
